// ===== rtl/tpis_pkg.sv =====
`timescale 1ns / 1ps
package tpis_pkg;

   // Path store geometry
   localparam int MAX_POINTS = 256;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = IDX_W + 1;

   // Item codes
   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_APPEND = 2'd1,
      FUNC_SAMPLE = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   // Register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_REBASE_EN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROTATE_EN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_Y  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_C  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ANCHOR_S  = 3'd5;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic [1:0]         func;
      logic [31:0]        time_stamp;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic               sample_ok;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               rotation_saturated;
      logic               store_overflowed;
   } rsp_type;

   // One stored path point
   typedef struct packed {
      logic [31:0]        t;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   // Memory read address choice
   typedef enum logic [2:0] {
      RD_FIRST,
      RD_LAST,
      RD_MID,
      RD_A,
      RD_B
   } rd_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_CHK_FIRST,
      ST_CHK_LAST,
      ST_SEARCH,
      ST_SRCH_CHK,
      ST_CAP_A,
      ST_CAP_B,
      ST_START,
      ST_MUL,
      ST_DIV,
      ST_CAP_LERP,
      ST_ROT_MUL,
      ST_OUT
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic       take;
      logic       clr;
      logic       append;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       cap_rd;
      logic       cap_a;
      logic       cap_b;
      logic       srch_init;
      logic       srch_upd;
      logic       lerp_start;
      logic       lerp_mul;
      logic       lerp_step;
      logic       cap_lerp;
      logic       rot_calc;
      logic       rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] func;
      logic       count_zero;
      logic       t_le_rd;
      logic       t_ge_rd;
      logic       rd_gt_t;
      logic       lo_lt_hi;
      logic       div_last;
      logic       rsp_free;
   } sts_type;

endpackage

// ===== rtl/tpis_lerp.sv =====
`timescale 1ns / 1ps
module tpis_lerp (
   input  logic               clock,
   input  logic               start,
   input  logic               mul,
   input  logic               step,
   input  logic signed [31:0] a,
   input  logic signed [31:0] b,
   input  logic [31:0]        n,
   input  logic [31:0]        d,
   output logic signed [31:0] res
);
   import tpis_pkg::*;

   logic               neg_ff, neg_in;
   logic [31:0]        mag_ff, mag_in;
   logic signed [31:0] a_ff;
   logic [31:0]        n_ff, d_ff;
   logic [31:0]        rem_ff, rem_in;
   logic [31:0]        num_ff, num_in;
   logic [31:0]        q_ff, q_in;
   logic signed [32:0] delta;
   logic signed [32:0] absd;
   logic [63:0]        prod;
   logic [32:0]        trial;
   logic               ge;
   logic signed [32:0] sum;

   // Segment delta as sign and magnitude
   always_comb begin
      delta = 33'(b) - 33'(a);
      absd  = delta[32] ? -delta : delta;
      neg_in = delta[32];
      mag_in = absd[31:0];
   end

   // Product plus half divisor, then one quotient bit a step
   always_comb begin
      prod  = 64'(mag_ff) * 64'(n_ff) + 64'(d_ff >> 1);
      trial = {rem_ff, num_ff[31]};
      ge    = trial >= {1'b0, d_ff};
      rem_in = rem_ff;
      num_in = num_ff;
      q_in   = q_ff;
      if (mul) begin
         rem_in = prod[63:32];
         num_in = prod[31:0];
         q_in   = '0;
      end else if (step) begin
         rem_in = ge ? 32'(trial - {1'b0, d_ff}) : trial[31:0];
         num_in = {num_ff[30:0], 1'b0};
         q_in   = {q_ff[30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
         a_ff   <= a;
         n_ff   <= n;
         d_ff   <= d;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      q_ff   <= q_in;
   end

   // Zero-length segment keeps the start point
   always_comb begin
      sum = neg_ff ? 33'(a_ff) - 33'(signed'({1'b0, q_ff}))
                   : 33'(a_ff) + 33'(signed'({1'b0, q_ff}));
      res = (d_ff == '0) ? a_ff : sum[31:0];
   end

endmodule

// ===== rtl/tpis_ctrl.sv =====
`timescale 1ns / 1ps
module tpis_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  tpis_pkg::sts_type sts,
   output tpis_pkg::cmd_type cmd,
   output logic              req_stall
);
   import tpis_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_DECODE;
         ST_DECODE: begin
            if (sts.func == FUNC_SAMPLE && !sts.count_zero) state_in = ST_CHK_FIRST;
            else state_in = ST_IDLE;
         end
         ST_CHK_FIRST: state_in = sts.t_le_rd ? ST_ROT_MUL : ST_CHK_LAST;
         ST_CHK_LAST:  state_in = sts.t_ge_rd ? ST_ROT_MUL : ST_SEARCH;
         ST_SEARCH:    state_in = sts.lo_lt_hi ? ST_SRCH_CHK : ST_CAP_A;
         ST_SRCH_CHK:  state_in = ST_SEARCH;
         ST_CAP_A:     state_in = ST_CAP_B;
         ST_CAP_B:     state_in = ST_START;
         ST_START:     state_in = ST_MUL;
         ST_MUL:       state_in = ST_DIV;
         ST_DIV:       if (sts.div_last) state_in = ST_CAP_LERP;
         ST_CAP_LERP:  state_in = ST_ROT_MUL;
         ST_ROT_MUL:   state_in = ST_OUT;
         ST_OUT:       if (sts.rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd = '0;
      cmd.rd_sel = RD_FIRST;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: cmd.take = req_valid;
         ST_DECODE: begin
            cmd.clr    = (sts.func == FUNC_CLEAR);
            cmd.append = (sts.func == FUNC_APPEND);
            cmd.rd_en  = (sts.func == FUNC_SAMPLE) && !sts.count_zero;
            cmd.rd_sel = RD_FIRST;
         end
         ST_CHK_FIRST: begin
            cmd.cap_rd = sts.t_le_rd;
            cmd.rd_en  = !sts.t_le_rd;
            cmd.rd_sel = RD_LAST;
         end
         ST_CHK_LAST: begin
            cmd.cap_rd    = sts.t_ge_rd;
            cmd.srch_init = !sts.t_ge_rd;
         end
         ST_SEARCH: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = sts.lo_lt_hi ? RD_MID : RD_A;
         end
         ST_SRCH_CHK: cmd.srch_upd = 1'b1;
         ST_CAP_A: begin
            cmd.cap_a  = 1'b1;
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_B;
         end
         ST_CAP_B:    cmd.cap_b = 1'b1;
         ST_START:    cmd.lerp_start = 1'b1;
         ST_MUL:      cmd.lerp_mul = 1'b1;
         ST_DIV:      cmd.lerp_step = 1'b1;
         ST_CAP_LERP: cmd.cap_lerp = 1'b1;
         ST_ROT_MUL:  cmd.rot_calc = 1'b1;
         ST_OUT:      cmd.rsp_load = sts.rsp_free;
         default:     cmd = '0;
      endcase
   end

endmodule

// ===== rtl/tpis_dp.sv =====
`timescale 1ns / 1ps
module tpis_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  tpis_pkg::cmd_type                   cmd,
   output tpis_pkg::sts_type                   sts,
   input  tpis_pkg::req_type                   req_data,
   input  logic                                csr_we,
   input  logic [tpis_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpis_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tpis_pkg::rsp_type                   rsp_data
);
   import tpis_pkg::*;

   typedef struct packed {
      logic               clip;
      logic signed [31:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [49:0] v);
      sat_type r;
      r.clip = 1'b0;
      r.val  = v[31:0];
      if (v > 50'sd2147483647) begin
         r.clip = 1'b1;
         r.val  = 32'sh7fffffff;
      end else if (v < -50'sd2147483648) begin
         r.clip = 1'b1;
         r.val  = 32'sh80000000;
      end
      return r;
   endfunction

   // Configuration
   logic               rebase_ff, rotate_ff;
   logic signed [31:0] anc_x_ff, anc_y_ff;
   logic signed [15:0] anc_c_ff, anc_s_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rebase_ff <= 1'b1;
         rotate_ff <= 1'b1;
         anc_x_ff  <= '0;
         anc_y_ff  <= '0;
         anc_c_ff  <= 16'sd16384;
         anc_s_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REBASE_EN: rebase_ff <= csr_wdata[0];
            CSR_ROTATE_EN: rotate_ff <= csr_wdata[0];
            CSR_ANCHOR_X:  anc_x_ff  <= csr_wdata[31:0];
            CSR_ANCHOR_Y:  anc_y_ff  <= csr_wdata[31:0];
            CSR_ANCHOR_C:  anc_c_ff  <= csr_wdata[15:0];
            CSR_ANCHOR_S:  anc_s_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Latched item
   req_type req_ff;
   always_ff @(posedge clock) begin
      if (cmd.take) req_ff <= req_data;
   end

   // Path store bookkeeping
   logic [CNT_W-1:0] count_ff;
   logic             ovf_ff;
   logic [31:0]      last_t_ff;
   logic             full;
   logic [31:0]      app_t;

   assign full  = (count_ff == CNT_W'(MAX_POINTS));
   assign app_t = (count_ff != '0 && req_ff.time_stamp < last_t_ff) ? last_t_ff
                                                                      : req_ff.time_stamp;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.clr) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else if (cmd.append) begin
         if (full) ovf_ff <= 1'b1;
         else count_ff <= count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !full) last_t_ff <= app_t;
   end

   // Search bounds
   logic [CNT_W-1:0] lo_ff, hi_ff, mid_ff, mid;
   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);

   always_ff @(posedge clock) begin
      if (cmd.srch_init) begin
         lo_ff <= CNT_W'(1);
         hi_ff <= count_ff - 1'b1;
      end else if (cmd.srch_upd) begin
         if (sts.rd_gt_t) hi_ff <= mid_ff;
         else lo_ff <= mid_ff + 1'b1;
      end
      if (cmd.rd_en && cmd.rd_sel == RD_MID) mid_ff <= mid;
   end

   // Point memory
   point_type        mem [MAX_POINTS];
   point_type        rd_ff;
   point_type        wr_pt;
   logic [CNT_W-1:0] rd_addr;

   always_comb begin
      unique case (cmd.rd_sel)
         RD_FIRST: rd_addr = '0;
         RD_LAST:  rd_addr = count_ff - 1'b1;
         RD_MID:   rd_addr = mid;
         RD_A:     rd_addr = lo_ff - 1'b1;
         RD_B:     rd_addr = lo_ff;
         default:  rd_addr = '0;
      endcase
      wr_pt.t = app_t;
      wr_pt.x = req_ff.pos_x;
      wr_pt.y = req_ff.pos_y;
      wr_pt.z = req_ff.pos_z;
   end

   always_ff @(posedge clock) begin
      if (cmd.append && !full) mem[count_ff[IDX_W-1:0]] <= wr_pt;
      if (cmd.rd_en) rd_ff <= mem[rd_addr[IDX_W-1:0]];
   end

   // Segment end points
   point_type pa_ff, pb_ff;
   always_ff @(posedge clock) begin
      if (cmd.cap_a) pa_ff <= rd_ff;
      if (cmd.cap_b) pb_ff <= rd_ff;
   end

   // Interpolation lanes
   logic [31:0]        seg_n, seg_d;
   logic signed [31:0] lx, ly, lz;
   assign seg_n = req_ff.time_stamp - pa_ff.t;
   assign seg_d = pb_ff.t - pa_ff.t;

   tpis_lerp u_lerp_x (.clock, .start(cmd.lerp_start), .mul(cmd.lerp_mul),
      .step(cmd.lerp_step), .a(pa_ff.x), .b(pb_ff.x), .n(seg_n), .d(seg_d), .res(lx));
   tpis_lerp u_lerp_y (.clock, .start(cmd.lerp_start), .mul(cmd.lerp_mul),
      .step(cmd.lerp_step), .a(pa_ff.y), .b(pb_ff.y), .n(seg_n), .d(seg_d), .res(ly));
   tpis_lerp u_lerp_z (.clock, .start(cmd.lerp_start), .mul(cmd.lerp_mul),
      .step(cmd.lerp_step), .a(pa_ff.z), .b(pb_ff.z), .n(seg_n), .d(seg_d), .res(lz));

   // Divide step counter
   logic [4:0] step_ff;
   always_ff @(posedge clock) begin
      if (cmd.lerp_mul) step_ff <= '0;
      else if (cmd.lerp_step) step_ff <= step_ff + 1'b1;
   end

   // Sampled point
   logic signed [31:0] sx_ff, sy_ff, sz_ff;
   always_ff @(posedge clock) begin
      if (cmd.cap_rd) begin
         sx_ff <= rd_ff.x;
         sy_ff <= rd_ff.y;
         sz_ff <= rd_ff.z;
      end else if (cmd.cap_lerp) begin
         sx_ff <= lx;
         sy_ff <= ly;
         sz_ff <= lz;
      end
   end

   // Rebase and rotation products
   logic signed [32:0] dx, dy, dx_ff, dy_ff;
   logic signed [48:0] pxc_ff, pys_ff, pyc_ff, pxs_ff;
   assign dx = 33'(sx_ff) - 33'(anc_x_ff);
   assign dy = 33'(sy_ff) - 33'(anc_y_ff);

   always_ff @(posedge clock) begin
      if (cmd.rot_calc) begin
         dx_ff  <= dx;
         dy_ff  <= dy;
         pxc_ff <= 49'(dx) * 49'(anc_c_ff);
         pys_ff <= 49'(dy) * 49'(anc_s_ff);
         pyc_ff <= 49'(dy) * 49'(anc_c_ff);
         pxs_ff <= 49'(dx) * 49'(anc_s_ff);
      end
   end

   // With rotation on, round half up by 14 bits; then saturate
   logic signed [49:0] rx, ry;
   sat_type            sat_x, sat_y;
   rsp_type            rsp_in;
   always_comb begin
      rx = (50'(pxc_ff) + 50'(pys_ff) + 50'sd8192) >>> 14;
      ry = (50'(pyc_ff) - 50'(pxs_ff) + 50'sd8192) >>> 14;
      if (rotate_ff) begin
         sat_x = sat32(rx);
         sat_y = sat32(ry);
      end else begin
         sat_x = sat32(50'(dx_ff));
         sat_y = sat32(50'(dy_ff));
      end
      rsp_in.sample_ok          = 1'b1;
      rsp_in.out_z              = sz_ff;
      rsp_in.store_overflowed   = ovf_ff;
      if (rebase_ff) begin
         rsp_in.out_x              = sat_x.val;
         rsp_in.out_y              = sat_y.val;
         rsp_in.rotation_saturated = sat_x.clip | sat_y.clip;
      end else begin
         rsp_in.out_x              = sx_ff;
         rsp_in.out_y              = sy_ff;
         rsp_in.rotation_saturated = 1'b0;
      end
   end

   // Output register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Status
   always_comb begin
      sts.func       = req_ff.func;
      sts.count_zero = (count_ff == '0);
      sts.t_le_rd    = req_ff.time_stamp <= rd_ff.t;
      sts.t_ge_rd    = req_ff.time_stamp >= rd_ff.t;
      sts.rd_gt_t    = rd_ff.t > req_ff.time_stamp;
      sts.lo_lt_hi   = lo_ff < hi_ff;
      sts.div_last   = (step_ff == 5'd31);
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

endmodule

// ===== rtl/timed_path_interpolation_sampler.sv =====
`timescale 1ns / 1ps
// Channel  Ports                          Direction
// req      req_valid req_stall req_data   in, item = func/time/position
// rsp      rsp_valid rsp_stall rsp_data   out, one item per sample of a non-empty path
// csr      csr_we csr_index csr_wdata     in, register write, no read-back
//
// Clear, append, the unused code and a sample of an empty path finish after decode. A sample
// that clamps to the first or the last point reads that point and goes on to the rotation;
// inside the path it runs a binary search (at most 8 probes for 256 points), each probe
// a read of the point memory and a check, and then the 32 steps of the bit-serial divider.
// Reset is synchronous and empties the path; the point memory itself is not cleared.
// A finished result sits in the output register; a stalled result holds the block in
// its last step until taken, while input items are taken only between items.
module timed_path_interpolation_sampler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tpis_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tpis_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [tpis_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tpis_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import tpis_pkg::*;

   cmd_type cmd;
   sts_type sts;

   tpis_ctrl u_ctrl (
      .clock,
      .reset,
      .req_valid,
      .sts,
      .cmd,
      .req_stall
   );

   tpis_dp u_dp (
      .clock,
      .reset,
      .cmd,
      .sts,
      .req_data,
      .csr_we,
      .csr_index,
      .csr_wdata,
      .rsp_valid,
      .rsp_stall,
      .rsp_data
   );

endmodule

// ===== rtl/tpis_checker.sv =====
`timescale 1ns / 1ps
module tpis_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tpis_pkg::rsp_type rsp_data
);
   import tpis_pkg::*;

   // A held result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Every result is a valid sample
   a_rsp_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sample_ok)
      else $error("result without sample_ok");

   // Nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result right after reset");

   // Block goes busy after taking an item
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second item taken back to back");

endmodule

bind timed_path_interpolation_sampler tpis_checker u_tpis_checker (
   .clock,
   .reset,
   .req_valid,
   .req_stall,
   .rsp_valid,
   .rsp_stall,
   .rsp_data
);
